@@ hw/rtl/ihpc_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the IPv4 header parse and check block.
package ihpc_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [15:0] C_COUNT_MAX   = 16'hFFFF;
    localparam logic [15:0] C_SUM_OK      = 16'hFFFF;
    localparam logic [15:0] C_HDR_MIN     = 16'd20;
    localparam logic [3:0]  C_VERSION     = 4'd4;
    localparam logic [16:0] C_MAX_END     = 17'd65515;
    localparam int unsigned C_BIT_RSV     = 15;
    localparam int unsigned C_BIT_MF      = 13;

    // Everything the checker needs about one finished packet.
    typedef struct packed {
        logic [15:0] count;
        logic [7:0]  first_byte;
        logic [15:0] dgram_len;
        logic [15:0] ident;
        logic [15:0] flags_off;
        logic [7:0]  proto;
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] sum;
    } t_record;

    // Queue handshake between the parser and the checker.
    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

endpackage

@@ hw/rtl/ihpc_if.sv @@
`timescale 1ns / 1ps
// Channel interfaces: packet bytes in, parsed header results out.
interface ihpc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface ihpc_hdr_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [5:0]  ihl_bytes;
    logic [15:0] dgram_len;
    logic [7:0]  protocol_number;
    logic [31:0] source_address;
    logic [31:0] destination_address;
    logic [15:0] identification;
    logic [15:0] frag_pos;
    logic        mf_flag;
    logic [15:0] pay_bytes;

    modport source (
        output valid, output status, output ihl_bytes, output dgram_len,
        output protocol_number, output source_address, output destination_address,
        output identification, output frag_pos, output mf_flag,
        output pay_bytes, input ready
    );
    modport sink (
        input valid, input status, input ihl_bytes, input dgram_len,
        input protocol_number, input source_address, input destination_address,
        input identification, input frag_pos, input mf_flag,
        input pay_bytes, output ready
    );
endinterface

@@ hw/rtl/ihpc_front.sv @@
`timescale 1ns / 1ps
// Byte parser: counts bytes, captures header fields and sums header words.
module ihpc_front
    import ihpc_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    ihpc_byte_if.sink       i_byte,
    input  t_q_stat         i_q_stat,
    output logic            o_push,
    output t_record         o_rec
);

    localparam logic [15:0] C_IDX_LEN_HI   = 16'd2;
    localparam logic [15:0] C_IDX_LEN_LO   = 16'd3;
    localparam logic [15:0] C_IDX_ID_HI    = 16'd4;
    localparam logic [15:0] C_IDX_ID_LO    = 16'd5;
    localparam logic [15:0] C_IDX_FLAG_HI  = 16'd6;
    localparam logic [15:0] C_IDX_FLAG_LO  = 16'd7;
    localparam logic [15:0] C_IDX_PROTO    = 16'd9;
    localparam logic [15:0] C_IDX_SRC_0    = 16'd12;
    localparam logic [15:0] C_IDX_SRC_1    = 16'd13;
    localparam logic [15:0] C_IDX_SRC_2    = 16'd14;
    localparam logic [15:0] C_IDX_SRC_3    = 16'd15;
    localparam logic [15:0] C_IDX_DST_0    = 16'd16;
    localparam logic [15:0] C_IDX_DST_1    = 16'd17;
    localparam logic [15:0] C_IDX_DST_2    = 16'd18;
    localparam logic [15:0] C_IDX_DST_3    = 16'd19;

    logic [15:0] r_count, n_count;
    logic [15:0] r_sum,   n_sum;
    logic [7:0]  r_high,  n_high;
    logic [7:0]  r_first, n_first;
    logic [15:0] r_len,   n_len;
    logic [15:0] r_ident, n_ident;
    logic [15:0] r_flags, n_flags;
    logic [7:0]  r_proto, n_proto;
    logic [31:0] r_src,   n_src;
    logic [31:0] r_dst,   n_dst;

    logic        w_accept;
    logic [5:0]  w_hl;
    logic [16:0] w_sum_raw;
    logic [7:0]  w_b;

    // A full queue holds off every byte, so ready never depends on the byte itself.
    assign i_byte.ready = !i_q_stat.full;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign w_b          = i_byte.data_byte;

    always_comb begin
        n_first = (r_count == 16'd0) ? w_b : r_first;
        w_hl    = {n_first[3:0], 2'b00};
        n_high  = r_high;
        n_sum   = r_sum;
        w_sum_raw = {1'b0, r_sum} + {1'b0, r_high, w_b};
        if (!r_count[0]) begin
            n_high = w_b;
        end else if ({10'd0, w_hl} > r_count) begin
            // End-around carry; a single fold never carries again.
            n_sum = w_sum_raw[15:0] + {15'd0, w_sum_raw[16]};
        end

        n_len   = r_len;
        n_ident = r_ident;
        n_flags = r_flags;
        n_proto = r_proto;
        n_src   = r_src;
        n_dst   = r_dst;
        unique case (r_count)
            C_IDX_LEN_HI, C_IDX_LEN_LO: begin
                n_len = {r_len[7:0], w_b};
            end
            C_IDX_ID_HI, C_IDX_ID_LO: begin
                n_ident = {r_ident[7:0], w_b};
            end
            C_IDX_FLAG_HI, C_IDX_FLAG_LO: begin
                n_flags = {r_flags[7:0], w_b};
            end
            C_IDX_PROTO: begin
                n_proto = w_b;
            end
            C_IDX_SRC_0, C_IDX_SRC_1, C_IDX_SRC_2, C_IDX_SRC_3: begin
                n_src = {r_src[23:0], w_b};
            end
            C_IDX_DST_0, C_IDX_DST_1, C_IDX_DST_2, C_IDX_DST_3: begin
                n_dst = {r_dst[23:0], w_b};
            end
            default: begin
            end
        endcase

        n_count = (r_count == C_COUNT_MAX) ? r_count : r_count + 16'd1;
    end

    assign o_push = w_accept && i_byte.last_byte;

    always_comb begin
        o_rec.count      = n_count;
        o_rec.first_byte = n_first;
        o_rec.dgram_len  = n_len;
        o_rec.ident      = n_ident;
        o_rec.flags_off  = n_flags;
        o_rec.proto      = n_proto;
        o_rec.src        = n_src;
        o_rec.dst        = n_dst;
        o_rec.sum        = n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_push) begin
            r_count <= '0;
            r_sum   <= '0;
            r_high  <= '0;
            r_first <= '0;
            r_len   <= '0;
            r_ident <= '0;
            r_flags <= '0;
            r_proto <= '0;
            r_src   <= '0;
            r_dst   <= '0;
        end else if (w_accept) begin
            r_count <= n_count;
            r_sum   <= n_sum;
            r_high  <= n_high;
            r_first <= n_first;
            r_len   <= n_len;
            r_ident <= n_ident;
            r_flags <= n_flags;
            r_proto <= n_proto;
            r_src   <= n_src;
            r_dst   <= n_dst;
        end
    end

endmodule

@@ hw/rtl/ihpc_queue.sv @@
`timescale 1ns / 1ps
// Short queue of finished packet records between parser and checker.
module ihpc_queue
    import ihpc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_push,
    input  t_record  i_rec,
    input  logic     i_pop,
    output t_q_stat  o_stat,
    output t_record  o_rec
);

    t_record                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    r_wr_ptr;
    logic [QUEUE_AW-1:0]    r_rd_ptr;
    logic [QUEUE_AW:0]      r_fill;

    assign o_stat.valid = (r_fill != '0);
    assign o_stat.full  = (r_fill == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_rec        = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

@@ hw/rtl/ihpc_back.sv @@
`timescale 1ns / 1ps
// Header checker: validates one packet record and registers its result.
module ihpc_back
    import ihpc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_q_stat     i_q_stat,
    input  t_record     i_rec,
    output logic        o_pop,
    ihpc_hdr_if.source  o_hdr
);

    logic        r_valid;
    logic        r_status;
    logic [5:0]  r_hl;
    logic [15:0] r_total;
    logic [7:0]  r_proto;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic [15:0] r_ident;
    logic [15:0] r_off;
    logic        r_mf;
    logic [15:0] r_pay;

    logic [5:0]  w_hl;
    logic [15:0] w_hl16;
    logic [15:0] w_off;
    logic        w_mf;
    logic [15:0] w_pay;
    logic [16:0] w_end;
    logic        w_bad;
    logic        w_load;

    always_comb begin
        w_hl   = {i_rec.first_byte[3:0], 2'b00};
        w_hl16 = {10'd0, w_hl};
        w_off  = {i_rec.flags_off[12:0], 3'b000};
        w_mf   = i_rec.flags_off[C_BIT_MF];
        w_pay  = (i_rec.dgram_len >= w_hl16) ? i_rec.dgram_len - w_hl16 : 16'd0;
        w_end  = {1'b0, w_off} + {1'b0, w_pay};
        w_bad  = (i_rec.count < C_HDR_MIN)
              || (i_rec.first_byte[7:4] != C_VERSION)
              || (w_hl16 < C_HDR_MIN)
              || (w_hl16 > i_rec.count)
              || (i_rec.dgram_len < w_hl16)
              || (i_rec.dgram_len > i_rec.count)
              || i_rec.flags_off[C_BIT_RSV]
              || (i_rec.sum != C_SUM_OK)
              || (w_mf && (w_pay[2:0] != 3'd0))
              || (w_end > C_MAX_END);
    end

    // The output register frees up in the same cycle its transfer completes.
    assign w_load = i_q_stat.valid && (!r_valid || o_hdr.ready);
    assign o_pop  = w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (o_hdr.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_status <= w_bad;
            r_hl     <= w_bad ? 6'd0  : w_hl;
            r_total  <= w_bad ? 16'd0 : i_rec.dgram_len;
            r_proto  <= w_bad ? 8'd0  : i_rec.proto;
            r_src    <= w_bad ? 32'd0 : i_rec.src;
            r_dst    <= w_bad ? 32'd0 : i_rec.dst;
            r_ident  <= w_bad ? 16'd0 : i_rec.ident;
            r_off    <= w_bad ? 16'd0 : w_off;
            r_mf     <= w_bad ? 1'b0  : w_mf;
            r_pay    <= w_bad ? 16'd0 : w_pay;
        end
    end

    assign o_hdr.valid               = r_valid;
    assign o_hdr.status              = r_status;
    assign o_hdr.ihl_bytes           = r_hl;
    assign o_hdr.dgram_len           = r_total;
    assign o_hdr.protocol_number     = r_proto;
    assign o_hdr.source_address      = r_src;
    assign o_hdr.destination_address = r_dst;
    assign o_hdr.identification      = r_ident;
    assign o_hdr.frag_pos            = r_off;
    assign o_hdr.mf_flag             = r_mf;
    assign o_hdr.pay_bytes           = r_pay;

endmodule

@@ hw/rtl/ipv4_header_parse_check_top.sv @@
`timescale 1ns / 1ps
// Top level of the IPv4 header parse and check block.
//
//  Port     Direction  Carries                          One transfer
//  i_byte   in         data_byte, last_byte             one packet byte
//  o_hdr    out        status and nine header fields    one packet result
//
// A byte is taken every cycle unless the queue is full; the parser updates its state in
// the cycle of the transfer. A final byte pushes a record into a two-entry queue; the
// checker then loads it into its output register, which holds the result for o_hdr.
// Synchronous active-low reset clears parser, queue and output valid.
// i_byte.ready drops only while the queue is full, which needs o_hdr stalled.

module ipv4_header_parse_check_top
    import ihpc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    ihpc_byte_if.sink    i_byte,
    ihpc_hdr_if.source   o_hdr
);

    logic     w_push;
    logic     w_pop;
    t_record  w_rec_in;
    t_record  w_rec_out;
    t_q_stat  w_q_stat;

    ihpc_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_rec    (w_rec_in)
    );

    ihpc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .i_pop   (w_pop),
        .o_stat  (w_q_stat),
        .o_rec   (w_rec_out)
    );

    ihpc_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_stat (w_q_stat),
        .i_rec    (w_rec_out),
        .o_pop    (w_pop),
        .o_hdr    (o_hdr)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> !w_q_stat.full)
        else $error("record pushed into a full queue");

    a_drain_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_q_stat.valid && !o_hdr.valid) |-> w_pop)
        else $error("queued record not moved into an empty output register");

    a_bad_fields_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hdr.valid && o_hdr.status) |->
            (o_hdr.dgram_len == 16'd0 && o_hdr.source_address == 32'd0
             && o_hdr.ihl_bytes == 6'd0 && o_hdr.pay_bytes == 16'd0))
        else $error("malformed packet result carries nonzero fields");

    a_good_lengths: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hdr.valid && !o_hdr.status) |->
            ({10'd0, o_hdr.ihl_bytes} >= C_HDR_MIN
             && o_hdr.pay_bytes + {10'd0, o_hdr.ihl_bytes} == o_hdr.dgram_len))
        else $error("valid header result has inconsistent lengths");

endmodule

@@ tb/ihpc_hdr_checker.sv @@
`timescale 1ns / 1ps
// Header checker: watches both channels, predicts each packet result and compares it.
module ihpc_hdr_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ihpc_byte_if i_byte_mon,
    ihpc_hdr_if  i_hdr_mon,
    output int   o_mismatches,
    output int   o_pending,
    output int   o_results,
    output int   o_valid_hdrs
);

    localparam int unsigned HDR_MIN_BYTES   = 20;
    localparam int unsigned PAYLOAD_END_MAX = 65515;
    localparam logic [3:0]  IP_VERSION      = 4'd4;
    localparam logic [15:0] HDR_SUM_GOOD    = 16'hFFFF;
    localparam logic [15:0] RX_COUNT_MAX    = 16'hFFFF;
    localparam int unsigned RSV_BIT         = 15;
    localparam int unsigned MF_BIT          = 13;
    localparam int unsigned MAX_REPORTS     = 10;

    typedef struct packed {
        logic        status;
        logic [5:0]  hdr_len;
        logic [15:0] dgram_len;
        logic [7:0]  proto;
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] ident;
        logic [15:0] frag_off;
        logic        more_frags;
        logic [15:0] pay_bytes;
    } t_hdr_result;

    t_hdr_result expected_hdrs[$];

    // Running view of the packet being received.
    logic [15:0] rx_count;
    logic [15:0] hdr_sum;
    logic [7:0]  hi_byte;
    logic [7:0]  ver_ihl;
    logic [15:0] tot_len;
    logic [15:0] ident_word;
    logic [15:0] flg_off;
    logic [7:0]  proto_byte;
    logic [31:0] src_word;
    logic [31:0] dst_word;

    int mismatch_cnt = 0;
    int result_cnt   = 0;
    int valid_cnt    = 0;

    task automatic clear_parse();
        rx_count   = '0;
        hdr_sum    = '0;
        hi_byte    = '0;
        ver_ihl    = '0;
        tot_len    = '0;
        ident_word = '0;
        flg_off    = '0;
        proto_byte = '0;
        src_word   = '0;
        dst_word   = '0;
    endtask

    task automatic finish_packet();
        t_hdr_result r;
        logic [5:0]  hl;
        logic [15:0] off;
        logic [15:0] pay;
        logic [17:0] span;
        logic        bad;
        hl   = {ver_ihl[3:0], 2'b00};
        off  = {flg_off[12:0], 3'b000};
        pay  = (tot_len >= 16'(hl)) ? tot_len - 16'(hl) : 16'd0;
        span = 18'(off) + 18'(pay);
        bad  = (rx_count < HDR_MIN_BYTES)
            || (ver_ihl[7:4] != IP_VERSION)
            || (hl < HDR_MIN_BYTES)
            || (16'(hl) > rx_count)
            || (tot_len < 16'(hl))
            || (tot_len > rx_count)
            || flg_off[RSV_BIT]
            || (hdr_sum != HDR_SUM_GOOD)
            || (flg_off[MF_BIT] && pay[2:0] != 3'd0)
            || (span > PAYLOAD_END_MAX);
        r = '0;
        r.status = bad;
        if (!bad) begin
            r.hdr_len    = hl;
            r.dgram_len  = tot_len;
            r.proto      = proto_byte;
            r.src_addr   = src_word;
            r.dst_addr   = dst_word;
            r.ident      = ident_word;
            r.frag_off   = off;
            r.more_frags = flg_off[MF_BIT];
            r.pay_bytes  = pay;
        end
        expected_hdrs.push_back(r);
    endtask

    task automatic absorb_byte(input logic [7:0] b, input logic fin);
        logic [15:0] idx;
        logic [5:0]  hl;
        logic [16:0] wsum;
        idx = rx_count;
        if (idx == 16'd0) ver_ihl = b;
        hl = {ver_ihl[3:0], 2'b00};
        // Even bytes are a word's high half; odd header bytes close it into the sum.
        if (!idx[0]) begin
            hi_byte = b;
        end else if (idx < 16'(hl)) begin
            wsum    = {1'b0, hdr_sum} + {1'b0, hi_byte, b};
            hdr_sum = wsum[15:0] + 16'(wsum[16]);
        end
        case (idx)
            16'd2, 16'd3: tot_len = {tot_len[7:0], b};
            16'd4, 16'd5: ident_word = {ident_word[7:0], b};
            16'd6, 16'd7: flg_off = {flg_off[7:0], b};
            16'd9: proto_byte = b;
            16'd12, 16'd13, 16'd14, 16'd15: src_word = {src_word[23:0], b};
            16'd16, 16'd17, 16'd18, 16'd19: dst_word = {dst_word[23:0], b};
            default: ;
        endcase
        if (rx_count != RX_COUNT_MAX) rx_count = rx_count + 16'd1;
        if (fin) begin
            finish_packet();
            clear_parse();
        end
    endtask

    task automatic note_mismatch(input string msg);
        if (mismatch_cnt < MAX_REPORTS) $display("%0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
        if (got_v !== want_v) begin
            note_mismatch($sformatf("result %0d, %s: expected %0h, got %0h",
                                    result_cnt, name, want_v, got_v));
        end
    endtask

    task automatic check_result();
        t_hdr_result want;
        result_cnt++;
        if (expected_hdrs.size() == 0) begin
            note_mismatch($sformatf("result %0d arrived with no packet outstanding",
                                    result_cnt));
            return;
        end
        want = expected_hdrs.pop_front();
        compare_field("status", 32'(want.status), 32'(i_hdr_mon.status));
        compare_field("ihl_bytes", 32'(want.hdr_len), 32'(i_hdr_mon.ihl_bytes));
        compare_field("dgram_len", 32'(want.dgram_len), 32'(i_hdr_mon.dgram_len));
        compare_field("protocol_number", 32'(want.proto), 32'(i_hdr_mon.protocol_number));
        compare_field("source_address", want.src_addr, i_hdr_mon.source_address);
        compare_field("destination_address", want.dst_addr,
                      i_hdr_mon.destination_address);
        compare_field("identification", 32'(want.ident), 32'(i_hdr_mon.identification));
        compare_field("frag_pos", 32'(want.frag_off), 32'(i_hdr_mon.frag_pos));
        compare_field("mf_flag", 32'(want.more_frags), 32'(i_hdr_mon.mf_flag));
        compare_field("pay_bytes", 32'(want.pay_bytes), 32'(i_hdr_mon.pay_bytes));
        if (!want.status) valid_cnt++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parse();
        end else begin
            if (i_byte_mon.valid && i_byte_mon.ready) begin
                absorb_byte(i_byte_mon.data_byte, i_byte_mon.last_byte);
            end
            if (i_hdr_mon.valid && i_hdr_mon.ready) check_result();
        end
        o_mismatches <= mismatch_cnt;
        o_pending    <= expected_hdrs.size();
        o_results    <= result_cnt;
        o_valid_hdrs <= valid_cnt;
    end

endmodule

@@ tb/tb_ipv4_header_parse_check_top.sv @@
`timescale 1ns / 1ps
// Testbench top: drives packet bytes and result backpressure, gives the verdict.
module tb_ipv4_header_parse_check_top;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_BYTES    = 40;
    localparam int PHASE_PKTS     = 2;
    localparam int HOLD_EVERY     = 12;

    localparam logic [15:0] FLAG_RSV = 16'h8000;
    localparam logic [15:0] FLAG_DF  = 16'h4000;
    localparam logic [15:0] FLAG_MF  = 16'h2000;

    typedef enum logic [1:0] {FILL_RANDOM, FILL_ZERO, FILL_ONES} t_fill;

    logic clk;
    logic rst_n;

    ihpc_byte_if byte_if ();
    ihpc_hdr_if  hdr_if ();

    int mismatches;
    int pending;
    int results;
    int valid_hdrs;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_sent     = 0;
    int pkts_sent      = 0;
    int idle_cycles    = 0;

    logic [7:0] pkt[$];

    ipv4_header_parse_check_top uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_byte  (byte_if),
        .o_hdr   (hdr_if)
    );

    ihpc_hdr_checker hdr_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_byte_mon   (byte_if),
        .i_hdr_mon    (hdr_if),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_results    (results),
        .o_valid_hdrs (valid_hdrs)
    );

    initial clk = 1'b0;
    always #CLK_HALF clk = ~clk;

    always @(posedge clk) begin
        hdr_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Any transfer on either channel counts as progress.
    always @(posedge clk) begin
        if ((byte_if.valid && byte_if.ready) || (hdr_if.valid && hdr_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("== FAIL ==");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if ($urandom_range(99) < send_idle_pct) begin
            byte_if.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
        end
        byte_if.valid     <= 1'b1;
        byte_if.data_byte <= b;
        byte_if.last_byte <= is_last;
        do @(posedge clk); while (byte_if.ready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt[i]) send_byte(pkt[i], i == pkt.size() - 1);
        pkts_sent++;
    endtask

    // Hold the sender until every outstanding result has been taken.
    task automatic drain();
        byte_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic build_packet(input logic [3:0] version, input logic [3:0] ihl,
                                input int pay_len, input int total_delta,
                                input logic [15:0] flags_off, input bit sum_ok,
                                input int pad, input int trunc, input t_fill fill);
        int          hl;
        int          hdr_bytes;
        logic [15:0] total;
        logic [15:0] sum16;
        logic [16:0] wide;
        logic [15:0] chk;
        logic [7:0]  fv;
        hl        = int'(ihl) * 4;
        hdr_bytes = (hl < 20) ? 20 : hl;
        total     = 16'(hl + pay_len + total_delta);
        pkt.delete();
        repeat (hdr_bytes) pkt.push_back(8'($urandom));
        pkt[0] = {version, ihl};
        pkt[2] = total[15:8];
        pkt[3] = total[7:0];
        pkt[6] = flags_off[15:8];
        pkt[7] = flags_off[7:0];
        if (fill != FILL_RANDOM) begin
            fv = (fill == FILL_ONES) ? 8'hFF : 8'h00;
            pkt[4] = fv;
            pkt[5] = fv;
            pkt[9] = fv;
            for (int i = 12; i < 20; i++) pkt[i] = fv;
        end
        pkt[10] = 8'h00;
        pkt[11] = 8'h00;
        sum16 = '0;
        for (int i = 0; i + 1 < hl; i += 2) begin
            wide  = {1'b0, sum16} + {1'b0, pkt[i], pkt[i+1]};
            sum16 = wide[15:0] + 16'(wide[16]);
        end
        chk = ~sum16;
        if (!sum_ok) chk = chk ^ (16'd1 << $urandom_range(15));
        pkt[10] = chk[15:8];
        pkt[11] = chk[7:0];
        repeat (pay_len + pad) pkt.push_back(8'($urandom));
        repeat (trunc) if (pkt.size() > 1) void'(pkt.pop_back());
    endtask

    // Mostly well-formed datagrams, the rest broken in one way or pure noise.
    task automatic random_packet();
        logic [3:0]  ver;
        logic [3:0]  ihl;
        logic [15:0] fo;
        int          pay;
        int          delta;
        int          pad;
        int          trunc;
        int          len;
        bit          sum_ok;
        bit          noise;
        ver    = 4'd4;
        ihl    = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
        pay    = $urandom_range(24);
        fo     = {1'b0, 1'($urandom), 1'b0, 13'($urandom_range(40))};
        delta  = 0;
        pad    = ($urandom_range(3) == 0) ? $urandom_range(1, 4) : 0;
        trunc  = 0;
        sum_ok = 1'b1;
        noise  = 1'b0;
        if ($urandom_range(3) == 0) begin
            fo[13] = 1'b1;
            pay    = 8 * $urandom_range(3);
        end
        if ($urandom_range(99) >= 70) begin
            case ($urandom_range(9))
                0: begin
                    ver = 4'($urandom);
                    if (ver == 4'd4) ver = 4'd6;
                end
                1: ihl = 4'($urandom_range(4));
                2: sum_ok = 1'b0;
                3: fo[15] = 1'b1;
                4: begin
                    fo[13] = 1'b1;
                    pay    = int'($urandom_range(1, 24)) | 1;
                end
                5: trunc = $urandom_range(1, pay + pad + 4);
                6: delta = 0 - int'($urandom_range(1, pay + 8));
                7: fo[12:0] = 13'($urandom_range(8180, 8191));
                8: delta = $urandom_range(1, 6);
                default: noise = 1'b1;
            endcase
        end
        if (noise) begin
            len = $urandom_range(1, 40);
            pkt.delete();
            repeat (len) pkt.push_back(8'($urandom));
        end else begin
            build_packet(ver, ihl, pay, delta, fo, sum_ok, pad, trunc, FILL_RANDOM);
        end
    endtask

    initial begin
        int start_bytes;
        int start_pkts;
        rst_n             = 1'b0;
        byte_if.valid     = 1'b0;
        byte_if.data_byte = 8'h00;
        byte_if.last_byte = 1'b0;
        hdr_if.ready      = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets, no idling.
        pkt = {8'h45};
        send_packet();
        build_packet(4'd4, 4'd5, 0, 0, 16'h0000, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd5, 0, 0, 16'h0000, 1, 0, 1, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd15, 8, 0, FLAG_MF | 16'd3, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd6, 4'd5, 4, 0, 16'h0000, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd4, 4, 0, 16'h0000, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd0, 4, 0, 16'h0000, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd15, 0, 0, 16'h0000, 1, 0, 8, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd5, 10, 0, 16'h0000, 1, 0, 3, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd6, 6, -10, 16'h0000, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd5, 4, 0, FLAG_RSV, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd5, 4, 0, 16'h0000, 0, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd5, 5, 0, FLAG_MF, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd5, 16, 0, FLAG_MF | 16'd100, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd5, 0, 0, 16'h1FFF, 1, 0, 0, FILL_RANDOM);
        send_packet();
        // Offset plus payload exactly at the limit, then one byte past it.
        build_packet(4'd4, 4'd5, 3, 0, 16'd8189, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd5, 4, 0, 16'd8189, 1, 0, 0, FILL_RANDOM);
        send_packet();
        build_packet(4'd4, 4'd5, 2, 0, FLAG_DF, 1, 0, 0, FILL_ONES);
        send_packet();
        build_packet(4'd4, 4'd5, 2, 0, 16'h0000, 1, 0, 0, FILL_ZERO);
        send_packet();
        build_packet(4'd4, 4'd5, 6, 0, 16'h0000, 1, 5, 0, FILL_RANDOM);
        send_packet();
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 0;
                end
                1: begin
                    send_idle_pct  = 81;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct <= 81;
                end
                default: begin
                    send_idle_pct  = 27;
                    recv_stall_pct <= 27;
                end
            endcase
            start_bytes = bytes_sent;
            start_pkts  = pkts_sent;
            while (bytes_sent - start_bytes < PHASE_BYTES
                   || pkts_sent - start_pkts < PHASE_PKTS) begin
                random_packet();
                send_packet();
                if (pkts_sent % HOLD_EVERY == 0) drain();
            end
            drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Summary: %0d bytes in %0d packets under four idle/stall mixes;",
                 bytes_sent, pkts_sent);
        $display("Summary: %0d results checked, %0d valid headers, %0d malformed.",
                 results, valid_hdrs, results - valid_hdrs);
        if (mismatches == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
